// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_PROP(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define ASSERT_PROP(lbl, prop)
`define ASSERT_NEXT(lbl, pre, post)
`endif
`endif

// ===== rtl/wnd_pkg.sv =====
// Types, constants and the month table of the week number block.
package wnd_pkg;

  localparam logic [22:0] JDN_EPOCH = 23'd1721119;
  localparam logic [22:0] JAN1_BASE = 23'd1721426;
  localparam logic [22:0] JAN1_YEAR0 = 23'd1721060;
  localparam logic [22:0] JAN1_YEARM1 = 23'd1720695;
  localparam logic [22:0] DAYS_PER_YEAR = 23'd365;

  localparam logic [12:0] RECIP_100 = 13'd5243;
  localparam logic [24:0] RECIP_7 = 25'd19173962;
  localparam logic [11:0] RECIP_7_SHORT = 12'd2341;

  localparam logic [3:0] OFS_ISO = 4'd10;
  localparam logic [3:0] OFS_SUNDAY = 4'd12;
  localparam logic [3:0] OFS_MONDAY = 4'd13;

  localparam logic [22:0] MIN_WEEK_DIFF = 23'd7;

  localparam logic [3:0] MONTH_MARCH = 4'd3;
  localparam logic [3:0] MONTH_OVER = 4'd15;

  localparam logic REG_WEEK1_HAS_JAN1 = 1'b0;
  localparam logic REG_START_MONDAY = 1'b1;

  localparam logic [1:0] LANE_PREV = 2'd1;
  localparam logic [1:0] LANE_SAME = 2'd2;
  localparam logic [1:0] LANE_NEXT = 2'd3;

  typedef logic [14:0] year_idx_t;

  typedef struct packed {
    logic [1:0]        sel;
    logic signed [9:0] term;
    logic [5:0]        day;
    logic              yzero;
    logic              yone;
  } date_ctl_t;

  // days from March 1 to the first of the month, with year zero Jan/Feb special
  function automatic logic signed [9:0] month_term(input logic [3:0] month,
                                                   input logic yzero);
    logic signed [9:0] res;
    case (month)
      4'd0:    res = yzero ? -10'sd91 : 10'sd275;
      4'd1:    res = yzero ? -10'sd60 : 10'sd306;
      4'd2:    res = yzero ? -10'sd29 : 10'sd337;
      4'd3:    res = 10'sd0;
      4'd4:    res = 10'sd31;
      4'd5:    res = 10'sd61;
      4'd6:    res = 10'sd92;
      4'd7:    res = 10'sd122;
      4'd8:    res = 10'sd153;
      4'd9:    res = 10'sd184;
      4'd10:   res = 10'sd214;
      4'd11:   res = 10'sd245;
      4'd12:   res = 10'sd275;
      4'd13:   res = 10'sd306;
      4'd14:   res = 10'sd337;
      default: res = 10'sd0;
    endcase
    return res;
  endfunction

endpackage

// ===== rtl/week_number_from_date.sv =====
// Week number and Julian day number of a Gregorian date, pipelined top level.
//
// Input channel: drive in_day, in_month and in_year with start high; the
// word is taken at a rising edge where start is high and busy is low. busy
// stays low, so a new date may be given in every cycle.
// Result channel: out_valid is high for one cycle with out_week_number and
// out_julian_day of each date taken, once it has passed the register stages
// below. Throughput is one date per cycle.
// The latency is set by eight register stages: year split, divide-by-100
// products, year day counts, day numbers, divide-by-7 product, week anchor,
// candidate select and the final divide-by-7 product.
// Configuration: APB registers week1_has_jan1 at 0 and start_monday at 4,
// which the user must write only while no date is in flight (unchecked).
// Reset clears the pipeline valid bits and loads the register defaults.
// The receiver cannot stall: each result is shown once and then dropped.
`include "assert_macros.svh"

module week_number_from_date
  import wnd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        start,
  output logic        busy,
  input  logic [5:0]  in_day,
  input  logic [3:0]  in_month,
  input  logic [13:0] in_year,
  output logic        out_valid,
  output logic [5:0]  out_week_number,
  output logic [22:0] out_julian_day
);

  logic        week1_has_jan1_r;
  logic        start_monday_r;
  logic        cfg_wr;
  logic        accept;

  logic [6:0]  stage_v_r;
  logic [6:0]  stage_v_nxt;
  logic        out_valid_r;

  year_idx_t   k_nxt [4];
  year_idx_t   k1_r [4];
  year_idx_t   k2_r [4];
  date_ctl_t   ctl_nxt;
  date_ctl_t   ctl1_r;
  date_ctl_t   ctl2_r;
  date_ctl_t   ctl3_r;

  logic [27:0] prod_a [4];
  logic [25:0] prod_b [4];
  logic [7:0]  q100_nxt [4];
  logic [5:0]  q400_nxt [4];
  logic [7:0]  q100_r [4];
  logic [5:0]  q400_r [4];

  logic [22:0] f_nxt [4];
  logic [22:0] f_r [4];

  logic [22:0] jd_nxt;
  logic [22:0] jn_nxt;
  logic [22:0] js_nxt;
  logic [22:0] jp_nxt;
  logic [22:0] jd4_r;
  logic [22:0] jn4_r;
  logic [22:0] js4_r;
  logic [22:0] jp4_r;

  logic [47:0] prod7;
  logic [20:0] q7_nxt;
  logic [20:0] q7_r;
  logic [22:0] jd5_r;
  logic [22:0] jn5_r;
  logic [22:0] js5_r;
  logic [22:0] jp5_r;

  logic [3:0]  offset;
  logic [22:0] anchor_nxt;
  logic [22:0] anchor_r;
  logic [22:0] jd6_r;
  logic [22:0] jn6_r;
  logic [22:0] js6_r;
  logic [22:0] jp6_r;

  logic [23:0] dn;
  logic [23:0] ds;
  logic [23:0] dp;
  logic [10:0] diff_nxt;
  logic [10:0] diff_r;
  logic [22:0] jd7_r;

  logic [22:0] prod_w;
  logic [5:0]  week_nxt;
  logic [5:0]  week_r;
  logic [22:0] jd_out_r;

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      week1_has_jan1_r <= 1'b0;
      start_monday_r   <= 1'b1;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_WEEK1_HAS_JAN1: week1_has_jan1_r <= pwdata[0];
        REG_START_MONDAY:   start_monday_r   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (paddr[2])
      REG_WEEK1_HAS_JAN1: prdata[0] = week1_has_jan1_r;
      REG_START_MONDAY:   prdata[0] = start_monday_r;
      default: ;
    endcase
  end

  // stage 1: split the year into lanes y-2 .. y+1 and pick the month term
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if ({1'b0, in_year} + 15'(i) < 15'd2) begin
        k_nxt[i] = '0;
      end else begin
        k_nxt[i] = {1'b0, in_year} + 15'(i) - 15'd2;
      end
    end
    if (in_month == MONTH_OVER) begin
      ctl_nxt.sel = LANE_NEXT;
    end else if (in_month >= MONTH_MARCH) begin
      ctl_nxt.sel = LANE_SAME;
    end else begin
      ctl_nxt.sel = LANE_PREV;
    end
    ctl_nxt.term  = month_term(in_month, in_year == 14'd0);
    ctl_nxt.day   = in_day;
    ctl_nxt.yzero = (in_year == 14'd0);
    ctl_nxt.yone  = (in_year == 14'd1);
  end

  // stage 2: divide each lane by 100 and 400
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      prod_a[i]   = 28'(k1_r[i]) * 28'(RECIP_100);
      prod_b[i]   = 26'(k1_r[i][14:2]) * 26'(RECIP_100);
      q100_nxt[i] = prod_a[i][26:19];
      q400_nxt[i] = prod_b[i][24:19];
    end
  end

  // stage 3: days before each lane's year
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      f_nxt[i] = 23'(k2_r[i]) * DAYS_PER_YEAR + 23'(k2_r[i][14:2])
                 - 23'(q100_r[i]) + 23'(q400_r[i]);
    end
  end

  // stage 4: day number of the date and of January 1 of three years
  always_comb begin
    jd_nxt = f_r[ctl3_r.sel] + {{13{ctl3_r.term[9]}}, ctl3_r.term}
             + 23'(ctl3_r.day) + JDN_EPOCH;
    jn_nxt = f_r[2] + JAN1_BASE;
    js_nxt = ctl3_r.yzero ? JAN1_YEAR0 : f_r[1] + JAN1_BASE;
    if (ctl3_r.yzero) begin
      jp_nxt = JAN1_YEARM1;
    end else if (ctl3_r.yone) begin
      jp_nxt = JAN1_YEAR0;
    end else begin
      jp_nxt = f_r[0] + JAN1_BASE;
    end
  end

  // stage 5: day number divided by 7
  assign prod7  = 48'(jd4_r) * 48'(RECIP_7);
  assign q7_nxt = prod7[47:27];

  // stage 6: week anchor
  always_comb begin
    if (!week1_has_jan1_r) begin
      offset = OFS_ISO;
    end else if (start_monday_r) begin
      offset = OFS_MONDAY;
    end else begin
      offset = OFS_SUNDAY;
    end
    anchor_nxt = 23'({q7_r, 3'b000}) - 23'(q7_r) + 23'(offset);
  end

  // stage 7: first year whose January 1 lies a full week before the anchor
  always_comb begin
    dn = {1'b0, anchor_r} - {1'b0, jn6_r};
    ds = {1'b0, anchor_r} - {1'b0, js6_r};
    dp = {1'b0, anchor_r} - {1'b0, jp6_r};
    if (!dn[23] && dn[22:0] >= MIN_WEEK_DIFF) begin
      diff_nxt = dn[10:0];
    end else if (!ds[23] && ds[22:0] >= MIN_WEEK_DIFF) begin
      diff_nxt = ds[10:0];
    end else begin
      diff_nxt = dp[10:0];
    end
  end

  // stage 8: week count
  assign prod_w   = 23'(diff_r) * 23'(RECIP_7_SHORT);
  assign week_nxt = prod_w[19:14];

  assign stage_v_nxt = {stage_v_r[5:0], accept};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_v_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      stage_v_r   <= stage_v_nxt;
      out_valid_r <= stage_v_r[6];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      k1_r[i]   <= k_nxt[i];
      k2_r[i]   <= k1_r[i];
      q100_r[i] <= q100_nxt[i];
      q400_r[i] <= q400_nxt[i];
      f_r[i]    <= f_nxt[i];
    end
    ctl1_r   <= ctl_nxt;
    ctl2_r   <= ctl1_r;
    ctl3_r   <= ctl2_r;
    jd4_r    <= jd_nxt;
    jn4_r    <= jn_nxt;
    js4_r    <= js_nxt;
    jp4_r    <= jp_nxt;
    q7_r     <= q7_nxt;
    jd5_r    <= jd4_r;
    jn5_r    <= jn4_r;
    js5_r    <= js4_r;
    jp5_r    <= jp4_r;
    anchor_r <= anchor_nxt;
    jd6_r    <= jd5_r;
    jn6_r    <= jn5_r;
    js6_r    <= js5_r;
    jp6_r    <= jp5_r;
    diff_r   <= diff_nxt;
    jd7_r    <= jd6_r;
    week_r   <= week_nxt;
    jd_out_r <= jd7_r;
  end

  assign out_valid       = out_valid_r;
  assign out_week_number = week_r;
  assign out_julian_day  = jd_out_r;

  `ASSERT_PROP(a_latency, (start && !busy) |-> ##8 out_valid)
  `ASSERT_PROP(a_no_extra, !(start && !busy) |-> ##8 !out_valid)
  `ASSERT_PROP(a_week_nonzero, out_valid |-> out_week_number != 6'd0)
  `ASSERT_NEXT(a_cfg_week1, cfg_wr && paddr[2] == REG_WEEK1_HAS_JAN1, week1_has_jan1_r == $past(pwdata[0]))

endmodule
